// ----- design/hbs_pkg.sv -----
// Shared types and constants of the heightmap bilinear sampler.
`timescale 1ns / 1ps

package hbs_pkg;

  // Item codes carried in the cmd field of an input beat.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  localparam int COORD_BITS = 16;
  localparam int GRID_SIDE_BITS = 9;
  localparam logic [GRID_SIDE_BITS-1:0] GRID_SIDE_RESET = 9'd256;

endpackage

// ----- design/hbs_channels.sv -----
// Valid/ready channel interfaces for the sampler input and result beats.
`timescale 1ns / 1ps

interface hbs_in_if #(
  parameter int HEIGHT_BITS = 16
);
  import hbs_pkg::*;

  logic                          valid;
  logic                          ready;
  cmd_t                          cmd;
  logic [COORD_BITS-1:0]         coord_x;
  logic [COORD_BITS-1:0]         coord_z;
  logic signed [HEIGHT_BITS-1:0] height_in;

  modport source (output valid, cmd, coord_x, coord_z, height_in, input ready);
  modport sink (input valid, cmd, coord_x, coord_z, height_in, output ready);
endinterface

interface hbs_out_if #(
  parameter int HEIGHT_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height_out;
  logic                          out_of_range;

  modport source (output valid, height_out, out_of_range, input ready);
  modport sink (input valid, height_out, out_of_range, output ready);
endinterface

// ----- design/heightmap_bilinear_sampler_top.sv -----
// Top level of the heightmap bilinear sampler: banked height store and blend pipeline.
`timescale 1ns / 1ps
//
// Usage
//   in_ch carries write and query beats; a write stores height_in at the cell given by
//   the integer parts of coord_x and coord_z, a query returns one beat on out_ch with the
//   bilinearly blended height, or zero with out_of_range set for a cell off the grid.
//   cfg_we/cfg_wdata set the grid side; write it only while the block is idle.
//   The store is split into four banks by column and row parity, so all four corners
//   of a query come out of one read of the banks.
// Throughput: one beat per cycle unless stalled, writes and queries in any mix.
// Pipeline: a query's bank read and its fields are registered at the accepting edge,
//   then the x blend is registered into s2 and the z blend into the output register.
// Writes complete at the edge that accepts them; a query in the next cycle sees them.
// Stall: each stage holds while the one after it is full and stalled; in_ch.ready
//   falls only when every stage holds a result, so bubbles are squeezed out first.
// Reset clears the pipeline valid bits and sets the grid side to 256; the height store
//   is not cleared, and a cell must be written before a query reads it.

module heightmap_bilinear_sampler_top #(
  parameter int MAX_SIDE    = 256,
  parameter int FRAC_BITS   = 8,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  hbs_in_if.sink                              in_ch,
  hbs_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [hbs_pkg::GRID_SIDE_BITS-1:0]  cfg_wdata
);
  import hbs_pkg::*;

  localparam int HB   = HEIGHT_BITS;
  localparam int IW   = COORD_BITS - FRAC_BITS;
  localparam int IXW  = (IW > 0) ? IW : 1;
  localparam int SW0  = $clog2(MAX_SIDE + 1);
  localparam int SW   = (SW0 > GRID_SIDE_BITS) ? SW0 : GRID_SIDE_BITS;
  localparam int CW   = (IXW + 1 > SW) ? IXW + 1 : SW;
  localparam int BC   = (MAX_SIDE + 1) / 2;
  localparam int BCW  = (BC > 1) ? $clog2(BC) : 1;
  localparam int BDEP = BC * BC;
  localparam int AW   = (BDEP > 1) ? $clog2(BDEP) : 1;
  localparam int PW   = HB + FRAC_BITS + 2;

  typedef logic [AW-1:0] addr_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fz;
    logic                 oor;
    logic                 edge_cell;
    logic                 px;
    logic                 pz;
  } s1_meta_t;

  typedef struct packed {
    logic signed [HB-1:0] lo;
    logic signed [HB-1:0] hi;
    logic signed [HB-1:0] h00;
    logic [FRAC_BITS-1:0] fz;
    logic                 oor;
    logic                 edge_cell;
  } s2_meta_t;

  // Bank row/column index, saturated so that off-grid neighbors stay inside the bank.
  function automatic logic [BCW-1:0] clamp_idx(input logic [CW-1:0] v);
    return (v >= CW'(BC)) ? BCW'(BC - 1) : BCW'(v);
  endfunction

  function automatic addr_t bank_addr(input logic [BCW-1:0] col, input logic [BCW-1:0] row);
    return AW'(int'(row) * BC + int'(col));
  endfunction

  // a + floor((b - a) * f / 2^FRAC_BITS); the arithmetic shift gives the floor.
  function automatic logic signed [HB-1:0] blend(input logic signed [HB-1:0] a,
                                                input logic signed [HB-1:0] b,
                                                input logic [FRAC_BITS-1:0] f);
    logic signed [HB:0]   d;
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    d = {b[HB-1], b} - {a[HB-1], a};
    p = $signed({{(FRAC_BITS + 1){d[HB]}}, d}) * $signed({{(HB + 2){1'b0}}, f});
    q = p >>> FRAC_BITS;
    return HB'(q) + a;
  endfunction

  // Configuration register.
  logic [GRID_SIDE_BITS-1:0] grid_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_RESET;
    end else if (cfg_we) begin
      grid_side_r <= cfg_wdata;
    end
  end

  // Pipeline control.
  logic     s1_v_r, s2_v_r, out_v_r;
  logic     load1, load2, load3;
  logic     in_accept;
  logic     in_ready_w;
  s1_meta_t s1_r, s1_nxt;
  s2_meta_t s2_r, s2_nxt;
  logic signed [HB-1:0] out_h_r, out_h_nxt;
  logic                 out_oor_r;

  assign load3     = !out_v_r || out_ch.ready;
  assign load2     = !s2_v_r || load3;
  assign load1     = !s1_v_r || load2;
  assign in_ready_w = load1;
  assign in_accept = in_ch.valid && load1;

  assign in_ch.ready = in_ready_w;

  // Address stage.
  logic [IXW-1:0]       ix, iz;
  logic [CW-1:0]        ix_e, iz_e, side;
  logic                 oor, edge_cell, wr_en;
  logic [BCW-1:0]       col_even, col_odd, row_even, row_odd;
  addr_t                wr_addr;

  always_comb begin
    ix   = IXW'(in_ch.coord_x >> FRAC_BITS);
    iz   = IXW'(in_ch.coord_z >> FRAC_BITS);
    ix_e = CW'(ix);
    iz_e = CW'(iz);
    side = (CW'(grid_side_r) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(grid_side_r);
    oor  = (ix_e >= side) || (iz_e >= side);
    edge_cell = ((ix_e + CW'(1)) >= side) || ((iz_e + CW'(1)) >= side);
    // Even-parity banks are read at column (ix+1)>>1 of the pair, odd-parity banks at ix>>1.
    col_even = clamp_idx((ix_e + CW'(1)) >> 1);
    col_odd  = clamp_idx(ix_e >> 1);
    row_even = clamp_idx((iz_e + CW'(1)) >> 1);
    row_odd  = clamp_idx(iz_e >> 1);
    wr_en    = in_accept && (in_ch.cmd == CMD_WRITE) && !oor;
    wr_addr  = bank_addr(col_odd, row_odd);
    s1_nxt.fx        = in_ch.coord_x[FRAC_BITS-1:0];
    s1_nxt.fz        = in_ch.coord_z[FRAC_BITS-1:0];
    s1_nxt.oor       = oor;
    s1_nxt.edge_cell = edge_cell;
    s1_nxt.px        = ix[0];
    s1_nxt.pz        = iz[0];
  end

  logic signed [HB-1:0] rd_data [4];

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic [1:0] K = 2'(k);
    logic [HB-1:0] rdata;
    addr_t         raddr;
    logic          we;

    assign raddr = bank_addr(K[0] ? col_odd : col_even, K[1] ? row_odd : row_even);
    assign we    = wr_en && (ix[0] == K[0]) && (iz[0] == K[1]);

    hbs_ram #(
      .WIDTH (HB),
      .DEPTH (BDEP)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (wr_addr),
      .wdata (in_ch.height_in),
      .re    (load1),
      .raddr (raddr),
      .rdata (rdata)
    );

    assign rd_data[k] = $signed(rdata);
  end

  // X blend stage: pick corners by parity and blend both rows.
  always_comb begin
    logic signed [HB-1:0] h00, h10, h01, h11;
    h00 = rd_data[{s1_r.pz, s1_r.px}];
    h10 = rd_data[{s1_r.pz, ~s1_r.px}];
    h01 = rd_data[{~s1_r.pz, s1_r.px}];
    h11 = rd_data[{~s1_r.pz, ~s1_r.px}];
    s2_nxt.lo        = blend(h00, h10, s1_r.fx);
    s2_nxt.hi        = blend(h01, h11, s1_r.fx);
    s2_nxt.h00       = h00;
    s2_nxt.fz        = s1_r.fz;
    s2_nxt.oor       = s1_r.oor;
    s2_nxt.edge_cell = s1_r.edge_cell;
  end

  // Z blend stage.
  always_comb begin
    if (s2_r.oor) begin
      out_h_nxt = '0;
    end else if (s2_r.edge_cell) begin
      out_h_nxt = s2_r.h00;
    end else begin
      out_h_nxt = blend(s2_r.lo, s2_r.hi, s2_r.fz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load1) begin
        s1_v_r <= in_accept && (in_ch.cmd == CMD_QUERY);
      end
      if (load2) begin
        s2_v_r <= s1_v_r;
      end
      if (load3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_r <= s1_nxt;
    end
    if (load2) begin
      s2_r <= s2_nxt;
    end
    if (load3) begin
      out_h_r   <= out_h_nxt;
      out_oor_r <= s2_r.oor;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.height_out   = out_h_r;
  assign out_ch.out_of_range = out_oor_r;

endmodule

// ----- design/hbs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/hbs_checker.sv -----
// Port-level assertions for the heightmap bilinear sampler, bound to its top level.
`timescale 1ns / 1ps

module hbs_checker #(
  parameter int HEIGHT_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [HEIGHT_BITS-1:0] out_height,
  input logic                          out_oor
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_height) && $stable(out_oor))
    else $error("result payload changed while stalled");

  // An off-grid query always reports a zero height.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_oor |-> out_height == '0)
    else $error("out-of-range result with nonzero height");

  // With the output register empty the pipeline can always take a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind heightmap_bilinear_sampler_top hbs_checker #(
  .HEIGHT_BITS (HEIGHT_BITS)
) u_hbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_height (out_ch.height_out),
  .out_oor    (out_ch.out_of_range)
);

// ----- tb/sv/hbs_sample_checker.sv -----
// Checker for the heightmap sampler: mirrors the height grid and compares result beats.
`timescale 1ns / 1ps

module hbs_sample_checker #(
  parameter int MAX_SIDE    = 256,
  parameter int FRAC_BITS   = 8,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  hbs_in_if                                  in_mon,
  hbs_out_if                                 out_mon,
  input  logic                               cfg_we,
  input  logic [hbs_pkg::GRID_SIDE_BITS-1:0] cfg_wdata,
  output int                                 mismatches,
  output int                                 outstanding
);
  import hbs_pkg::*;

  typedef struct {
    logic signed [HEIGHT_BITS-1:0] height;
    logic                          off_grid;
  } sample_t;

  logic signed [HEIGHT_BITS-1:0] grid_heights [MAX_SIDE*MAX_SIDE];
  logic [GRID_SIDE_BITS-1:0]     side_reg = GRID_SIDE_RESET;
  sample_t                       expected_samples [$];
  int                            error_count = 0;
  int                            waiting = 0;

  assign mismatches  = error_count;
  assign outstanding = waiting;

  function automatic int active_side();
    return (side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg);
  endfunction

  function automatic longint corner(int col, int row);
    return longint'(grid_heights[row*MAX_SIDE + col]);
  endfunction

  // Floor-rounded blend: the arithmetic shift rounds toward minus infinity.
  function automatic longint lerp(longint a, longint b, int frac);
    return a + (((b - a) * longint'(frac)) >>> FRAC_BITS);
  endfunction

  function automatic sample_t interpolate(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cz);
    int      side;
    int      col;
    int      row;
    int      fx;
    int      fz;
    longint  h;
    longint  lo;
    longint  hi;
    sample_t s;
    side = active_side();
    col  = int'(cx) >> FRAC_BITS;
    row  = int'(cz) >> FRAC_BITS;
    fx   = int'(cx) & ((1 << FRAC_BITS) - 1);
    fz   = int'(cz) & ((1 << FRAC_BITS) - 1);
    if (col >= side || row >= side) begin
      s.height   = '0;
      s.off_grid = 1'b1;
      return s;
    end
    h = corner(col, row);
    if (col + 1 < side && row + 1 < side) begin
      lo = lerp(h, corner(col + 1, row), fx);
      hi = lerp(corner(col, row + 1), corner(col + 1, row + 1), fx);
      h  = lerp(lo, hi, fz);
    end
    s.height   = h[HEIGHT_BITS-1:0];
    s.off_grid = 1'b0;
    return s;
  endfunction

  always @(posedge clk) begin
    sample_t want;
    int      col;
    int      row;
    if (!rst_n) begin
      side_reg = GRID_SIDE_RESET;
      expected_samples.delete();
    end else begin
      // Results are retired before new queries are queued, so a query accepted
      // on this edge can never be matched against a beat leaving on the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat: expected none, got height %0d oor %0b",
                   $time, out_mon.height_out, out_mon.out_of_range);
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.height_out !== want.height) begin
            error_count++;
            $display("%0t: height_out mismatch: expected %0d, got %0d",
                     $time, want.height, out_mon.height_out);
          end
          if (out_mon.out_of_range !== want.off_grid) begin
            error_count++;
            $display("%0t: out_of_range mismatch: expected %0b, got %0b",
                     $time, want.off_grid, out_mon.out_of_range);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd == CMD_WRITE) begin
          col = int'(in_mon.coord_x) >> FRAC_BITS;
          row = int'(in_mon.coord_z) >> FRAC_BITS;
          if (col < active_side() && row < active_side())
            grid_heights[row*MAX_SIDE + col] = in_mon.height_in;
        end else begin
          expected_samples.push_back(interpolate(in_mon.coord_x, in_mon.coord_z));
        end
      end
      if (cfg_we)
        side_reg = cfg_wdata;
    end
    waiting = expected_samples.size();
  end

endmodule

// ----- tb/sv/tb_heightmap_bilinear_sampler_top.sv -----
// Testbench top for the heightmap sampler: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_heightmap_bilinear_sampler_top;
  import hbs_pkg::*;

  localparam int MAX_SIDE    = 256;
  localparam int FRAC_BITS   = 8;
  localparam int HEIGHT_BITS = 16;
  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 200000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [GRID_SIDE_BITS-1:0] cfg_wdata = '0;
  logic                      sink_ready = 1'b0;
  bit                        calm = 1'b0;
  bit                        written [MAX_SIDE*MAX_SIDE];
  int                        cur_side = MAX_SIDE;
  int                        cycles = 0;
  int                        n_writes = 0;
  int                        n_queries = 0;
  int                        n_edge = 0;
  int                        n_off = 0;
  int                        n_sides = 0;
  int                        fail_count;
  int                        pending;

  hbs_in_if #(.HEIGHT_BITS(HEIGHT_BITS)) in_ch ();
  hbs_out_if #(.HEIGHT_BITS(HEIGHT_BITS)) out_ch ();

  heightmap_bilinear_sampler_top #(
    .MAX_SIDE(MAX_SIDE),
    .FRAC_BITS(FRAC_BITS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  hbs_sample_checker #(
    .MAX_SIDE(MAX_SIDE),
    .FRAC_BITS(FRAC_BITS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_mon(in_ch),
    .out_mon(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .mismatches(fail_count),
    .outstanding(pending)
  );

  assign out_ch.ready = sink_ready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    sink_ready <= calm || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int eff_side();
    return (cur_side > MAX_SIDE) ? MAX_SIDE : cur_side;
  endfunction

  function automatic logic signed [HEIGHT_BITS-1:0] rand_height();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(HEIGHT_BITS-1){1'b0}}};
      1:       return {1'b0, {(HEIGHT_BITS-1){1'b1}}};
      default: return HEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic int rand_frac();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return (1 << FRAC_BITS) - 1;
      default: return $urandom_range(0, (1 << FRAC_BITS) - 1);
    endcase
  endfunction

  // Leans toward the last row or column so that edge cells come up often.
  function automatic int pick_cell(int side);
    if ($urandom_range(0, 5) == 0)
      return side - 1;
    return $urandom_range(0, side - 1);
  endfunction

  task automatic drive_beat(cmd_t cmd, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cz,
                            logic signed [HEIGHT_BITS-1:0] h);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.coord_x   <= cx;
    in_ch.coord_z   <= cz;
    in_ch.height_in <= h;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic store_at(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cz,
                          logic signed [HEIGHT_BITS-1:0] h);
    int col;
    int row;
    col = int'(cx) >> FRAC_BITS;
    row = int'(cz) >> FRAC_BITS;
    drive_beat(CMD_WRITE, cx, cz, h);
    n_writes++;
    if (col < eff_side() && row < eff_side())
      written[row*MAX_SIDE + col] = 1'b1;
  endtask

  task automatic query_at(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cz);
    int col;
    int row;
    col = int'(cx) >> FRAC_BITS;
    row = int'(cz) >> FRAC_BITS;
    if (col >= eff_side() || row >= eff_side())
      n_off++;
    else if (col + 1 >= eff_side() || row + 1 >= eff_side())
      n_edge++;
    n_queries++;
    drive_beat(CMD_QUERY, cx, cz, HEIGHT_BITS'($urandom));
  endtask

  // Writes whichever corners the query will read and that hold nothing yet,
  // then issues the query itself.
  task automatic sample_cell(int col, int row, int fx, int fz);
    int side;
    bit blended;
    side    = eff_side();
    blended = (col + 1 < side) && (row + 1 < side);
    if (col < side && row < side) begin
      for (int dz = 0; dz < 2; dz++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if ((dx == 0 && dz == 0) || blended) begin
            if (!written[(row + dz)*MAX_SIDE + col + dx])
              store_at(COORD_BITS'(((col + dx) << FRAC_BITS) | $urandom_range(0, 255)),
                       COORD_BITS'(((row + dz) << FRAC_BITS) | $urandom_range(0, 255)),
                       rand_height());
          end
        end
      end
    end
    query_at(COORD_BITS'((col << FRAC_BITS) | fx), COORD_BITS'((row << FRAC_BITS) | fz));
  endtask

  task automatic wait_for_results(int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_side(int side);
    wait_for_results(LATENCY + 2);
    cfg_we    <= 1'b1;
    cfg_wdata <= GRID_SIDE_BITS'(side);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_side = side;
    n_sides++;
  endtask

  task automatic run_phase(int side, int count, bit quiet);
    int es;
    int r;
    int off;
    int other;
    set_side(side);
    calm = quiet;
    for (int i = 0; i < count; i++) begin
      es = eff_side();
      r  = $urandom_range(0, 99);
      if (r < 55 && es > 0) begin
        sample_cell(pick_cell(es), pick_cell(es), rand_frac(), rand_frac());
      end else if (r < 70) begin
        if (es < MAX_SIDE) begin
          off   = $urandom_range(es, MAX_SIDE - 1);
          other = $urandom_range(0, MAX_SIDE - 1);
          if ($urandom_range(0, 1) == 0)
            sample_cell(off, other, rand_frac(), rand_frac());
          else
            sample_cell(other, off, rand_frac(), rand_frac());
        end else begin
          sample_cell($urandom_range(0, MAX_SIDE - 1), $urandom_range(0, MAX_SIDE - 1),
                      rand_frac(), rand_frac());
        end
      end else if (r < 90) begin
        store_at(COORD_BITS'($urandom), COORD_BITS'($urandom), rand_height());
      end else begin
        sample_cell($urandom_range(0, MAX_SIDE - 1), $urandom_range(0, MAX_SIDE - 1),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end
      if ($urandom_range(0, 39) == 0)
        wait_for_results(0);
    end
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_WRITE;
    in_ch.coord_x   <= '0;
    in_ch.coord_z   <= '0;
    in_ch.height_in <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset side: extreme heights, extreme fractions, all edges.
    store_at(16'h0000, 16'h0000, -16'sd32768);
    store_at(16'h0100, 16'h0000, 16'sd32767);
    store_at(16'h0000, 16'h0100, 16'sd32767);
    store_at(16'h0100, 16'h0100, -16'sd32768);
    query_at(16'h0000, 16'h0000);
    query_at(16'h00FF, 16'h00FF);
    query_at(16'h0080, 16'h0080);
    query_at(16'h00FF, 16'h0000);
    query_at(16'h0000, 16'h00FF);
    store_at(16'hFF00, 16'hFF00, 16'sd32767);
    query_at(16'hFFFF, 16'hFFFF);
    store_at(16'hFF00, 16'h0A00, -16'sd5);
    query_at(16'hFF80, 16'h0A40);
    store_at(16'h0A00, 16'hFF00, 16'sd77);
    query_at(16'h0A7F, 16'hFFC0);

    // A side of 2, an empty grid, a single cell and a saturated side.
    set_side(2);
    query_at(16'h0100, 16'h0000);
    query_at(16'h0000, 16'h0180);
    query_at(16'h0200, 16'h0000);
    store_at(16'h0500, 16'h0000, 16'sd999);
    set_side(0);
    store_at(16'h0000, 16'h0000, 16'sd123);
    query_at(16'h0000, 16'h0000);
    set_side(1);
    query_at(16'h0080, 16'h0080);
    set_side(511);
    query_at(16'hFFFF, 16'hFFFF);
    query_at(16'h0040, 16'h00C0);

    run_phase(3, 30, 1'b0);
    run_phase(256, 20, 1'b1);
    run_phase(1, 15, 1'b0);
    run_phase(0, 15, 1'b0);
    run_phase(511, 15, 1'b0);
    run_phase(2, 20, 1'b0);
    run_phase($urandom_range(4, 32), 25, 1'b0);
    run_phase($urandom_range(2, 256), 12, 1'b0);
    run_phase(256, 10, 1'b0);

    wait_for_results(LATENCY + 4);
    $display("Covered %0d writes and %0d queries (%0d on an edge cell, %0d off the grid)",
             n_writes, n_queries, n_edge, n_off);
    $display("across %0d grid-side settings, including 0, 1, 2, 256 and a saturating 511.",
             n_sides);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- heightmap_bilinear_sampler_top.f -----
design/hbs_pkg.sv
design/hbs_channels.sv
design/hbs_ram.sv
design/heightmap_bilinear_sampler_top.sv
design/hbs_checker.sv
tb/sv/hbs_sample_checker.sv
tb/sv/tb_heightmap_bilinear_sampler_top.sv
